// ----- rtl/sdf_pkg.sv -----
`timescale 1ns / 1ps

package sdf_pkg;

  localparam int VALUE_W = 32;
  localparam int COUNT_W = 4;
  localparam int CHAR_W  = 7;
  localparam int POS_W   = 4;
  localparam int STEP_W  = $clog2(VALUE_W);

  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 7'd43;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;

  // One classified number waiting for conversion
  typedef struct packed {
    logic               neg;
    logic [VALUE_W-1:0] mag;
    logic [COUNT_W-1:0] count;
  } job_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } back_state_t;

endpackage

// ----- rtl/sdf_in_if.sv -----
`timescale 1ns / 1ps

interface sdf_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [sdf_pkg::VALUE_W-1:0] value;
  logic [sdf_pkg::COUNT_W-1:0]       digit_count;

  modport source(output valid, value, digit_count, input ready);
  modport sink(input valid, value, digit_count, output ready);
endinterface

// ----- rtl/sdf_out_if.sv -----
`timescale 1ns / 1ps

interface sdf_out_if;
  logic                       valid;
  logic                       ready;
  logic [sdf_pkg::CHAR_W-1:0] char_code;
  logic [sdf_pkg::POS_W-1:0]  position;
  logic                       last;

  modport source(output valid, char_code, position, last, input ready);
  modport sink(input valid, char_code, position, last, output ready);
endinterface

// ----- rtl/signed_decimal_formatter_unit.sv -----
// Signed decimal formatter. Each input item (a 32-bit two's complement value and a
// digit count) produces a run of ASCII items on the output: a '+' or '-' sign at
// position 0, then digit_count decimal digits of the magnitude (counts above
// MAX_DIGITS are clamped), most significant first, leading zeros kept and higher
// digits dropped; last marks the final item. A two-entry queue after the input
// stage holds numbers while the converter works. The converter loads a number, runs
// the 32 shift-add-3 steps of the binary to BCD loop, then emits its characters in
// turn, holding while an output item is not taken; it takes the next number only
// after the last character. Results leave through a registered output.
`timescale 1ns / 1ps

module signed_decimal_formatter_unit #(
  parameter int MAX_DIGITS = 10
) (
  input  logic      clk,
  input  logic      rst_n,
  sdf_in_if.sink    in_ch,
  sdf_out_if.source out_ch
);
  import sdf_pkg::*;

  job_t front_job;
  job_t head_job;
  logic push;
  logic pop;
  logic q_full;
  logic q_empty;

  sdf_front #(.MAX_DIGITS(MAX_DIGITS)) u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (push),
    .job    (front_job)
  );

  sdf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (front_job),
    .pop      (pop),
    .head_job (head_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  sdf_back #(.MAX_DIGITS(MAX_DIGITS)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_job (head_job),
    .q_empty  (q_empty),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

// ----- rtl/sdf_front.sv -----
`timescale 1ns / 1ps

module sdf_front #(
  parameter int MAX_DIGITS = 10
) (
  sdf_in_if.sink       in_ch,
  input  logic         q_full,
  output logic         push,
  output sdf_pkg::job_t job
);
  import sdf_pkg::*;

  logic [VALUE_W-1:0] raw;

  assign raw         = VALUE_W'(in_ch.value);
  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  always_comb begin
    job.neg   = raw[VALUE_W-1];
    // two's complement magnitude; the most negative value wraps to itself
    job.mag   = raw[VALUE_W-1] ? (~raw + VALUE_W'(1)) : raw;
    job.count = (in_ch.digit_count > COUNT_W'(MAX_DIGITS)) ? COUNT_W'(MAX_DIGITS)
                                                           : in_ch.digit_count;
  end

endmodule

// ----- rtl/sdf_queue.sv -----
`timescale 1ns / 1ps

module sdf_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  sdf_pkg::job_t push_job,
  input  logic          pop,
  output sdf_pkg::job_t head_job,
  output logic          full,
  output logic          empty
);
  import sdf_pkg::*;

  localparam int DEPTH = 2;

  job_t       slot_r [DEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;

  assign full     = (fill_r == 2'(DEPTH));
  assign empty    = (fill_r == 2'd0);
  assign head_job = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? !rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ----- rtl/sdf_back.sv -----
`timescale 1ns / 1ps

module sdf_back #(
  parameter int MAX_DIGITS = 10
) (
  input  logic          clk,
  input  logic          rst_n,
  input  sdf_pkg::job_t head_job,
  input  logic          q_empty,
  output logic          pop,
  sdf_out_if.source     out_ch
);
  import sdf_pkg::*;

  localparam int BCD_W = 4 * MAX_DIGITS;
  localparam int DIG_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  back_state_t        state_r, state_nxt;
  logic [BCD_W-1:0]   bcd_r, bcd_nxt;
  logic [VALUE_W-1:0] shift_r, shift_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic               neg_r, neg_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;
  logic [POS_W-1:0]   idx_r, idx_nxt;

  logic               o_valid_r, o_valid_nxt;
  logic [CHAR_W-1:0]  o_char_r, o_char_nxt;
  logic [POS_W-1:0]   o_pos_r, o_pos_nxt;
  logic               o_last_r, o_last_nxt;

  logic               emit;
  logic               conv_done;
  logic [3:0]         digit_arr [MAX_DIGITS];
  logic [COUNT_W-1:0] dig_off;
  logic [3:0]         digit;

  // one shift-add-3 step; a carry out of the top digit is dropped, which
  // keeps the result modulo 10^MAX_DIGITS
  function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] b,
                                               input logic bit_in);
    logic [BCD_W-1:0] adj;
    adj = b;
    for (int d = 0; d < MAX_DIGITS; d++) begin
      if (b[4*d +: 4] >= 4'd5) begin
        adj[4*d +: 4] = b[4*d +: 4] + 4'd3;
      end
    end
    return {adj[BCD_W-2:0], bit_in};
  endfunction

  always_comb begin
    for (int d = 0; d < MAX_DIGITS; d++) begin
      digit_arr[d] = bcd_r[4*d +: 4];
    end
  end

  assign conv_done = (step_r == STEP_W'(VALUE_W - 1));
  assign emit      = (state_r == ST_EMIT) && (!o_valid_r || out_ch.ready);
  assign pop       = (state_r == ST_IDLE) && !q_empty;
  assign dig_off   = cnt_r - COUNT_W'(idx_r);
  assign digit     = digit_arr[dig_off[DIG_W-1:0]];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (!q_empty) state_nxt = ST_CONV;
      ST_CONV: if (conv_done) state_nxt = ST_EMIT;
      ST_EMIT: if (emit && (idx_r == POS_W'(cnt_r))) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and output register
  always_comb begin
    bcd_nxt     = bcd_r;
    shift_nxt   = shift_r;
    step_nxt    = step_r;
    neg_nxt     = neg_r;
    cnt_nxt     = cnt_r;
    idx_nxt     = idx_r;
    o_char_nxt  = o_char_r;
    o_pos_nxt   = o_pos_r;
    o_last_nxt  = o_last_r;
    o_valid_nxt = out_ch.ready ? 1'b0 : o_valid_r;
    unique case (state_r)
      ST_IDLE: begin
        bcd_nxt   = '0;
        shift_nxt = head_job.mag;
        step_nxt  = '0;
        neg_nxt   = head_job.neg;
        cnt_nxt   = head_job.count;
        idx_nxt   = '0;
      end
      ST_CONV: begin
        bcd_nxt   = dabble(bcd_r, shift_r[VALUE_W-1]);
        shift_nxt = {shift_r[VALUE_W-2:0], 1'b0};
        step_nxt  = step_r + STEP_W'(1);
      end
      ST_EMIT: begin
        if (emit) begin
          o_valid_nxt = 1'b1;
          o_pos_nxt   = idx_r;
          o_last_nxt  = (idx_r == POS_W'(cnt_r));
          if (idx_r == '0) begin
            o_char_nxt = neg_r ? CHAR_MINUS : CHAR_PLUS;
          end else begin
            o_char_nxt = CHAR_ZERO + CHAR_W'(digit);
          end
          idx_nxt = idx_r + POS_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      o_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      o_valid_r <= o_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bcd_r    <= bcd_nxt;
    shift_r  <= shift_nxt;
    step_r   <= step_nxt;
    neg_r    <= neg_nxt;
    cnt_r    <= cnt_nxt;
    idx_r    <= idx_nxt;
    o_char_r <= o_char_nxt;
    o_pos_r  <= o_pos_nxt;
    o_last_r <= o_last_nxt;
  end

  assign out_ch.valid     = o_valid_r;
  assign out_ch.char_code = o_char_r;
  assign out_ch.position  = o_pos_r;
  assign out_ch.last      = o_last_r;

endmodule

// ----- rtl/sdf_checker.sv -----
`timescale 1ns / 1ps

module sdf_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [sdf_pkg::CHAR_W-1:0] out_char_code,
  input logic [sdf_pkg::POS_W-1:0]  out_position,
  input logic                       out_last
);
  import sdf_pkg::*;

  // a stalled item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char_code)
      && $stable(out_position) && $stable(out_last))
    else $error("output item changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_sign_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_position == '0) |->
      (out_char_code == CHAR_PLUS) || (out_char_code == CHAR_MINUS))
    else $error("position 0 is not a sign");

  a_digit_rest: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_position != '0) |->
      (out_char_code >= CHAR_ZERO) && (out_char_code <= CHAR_ZERO + CHAR_W'(9)))
    else $error("non-digit after the sign");

endmodule

bind signed_decimal_formatter_unit sdf_checker u_sdf_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_char_code (out_ch.char_code),
  .out_position  (out_ch.position),
  .out_last      (out_ch.last)
);
